// File: rtl/core/rpcd_pkg.sv
// Shared types, constants and helpers for the radiometer packet channel demux.
package rpcd_pkg;

    // Width of the scan line counter; it wraps at this width.
    localparam int LINE_BITS = 16;

    localparam logic [16:0] MIN_LENGTH    = 17'd1018;
    localparam logic [10:0] WINDOW_END    = 11'd1016;
    localparam logic [10:0] LAST_BYTE     = 11'd1015;
    localparam logic [10:0] MARKER1_START = 11'd512;
    localparam logic [10:0] OTHER_START   = 11'd8;
    localparam logic [4:0]  NUM_CHANNELS  = 5'd18;
    localparam logic [4:0]  LAST_CHANNEL  = 5'd17;

    localparam logic [2:0] MARKER_IMAGER = 3'd1;
    localparam logic [2:0] MARKER_SCAN_A = 3'd2;
    localparam logic [2:0] MARKER_SCAN_B = 3'd3;
    localparam logic [2:0] MARKER_SCAN_C = 3'd4;

    localparam logic [6:0] COLUMN_BASE_IMAGER = 7'd0;
    localparam logic [6:0] COLUMN_BASE_SCAN_A = 7'd14;
    localparam logic [6:0] COLUMN_BASE_SCAN_B = 7'd42;
    localparam logic [6:0] COLUMN_BASE_SCAN_C = 7'd70;

    // One payload byte with its packet framing.
    typedef struct packed {
        logic        valid;
        logic [7:0]  payload_byte;
        logic [16:0] payload_length;
        logic        start_of_packet;
    } t_item;

    // One demultiplexed sample.
    typedef struct packed {
        logic [15:0] sample_value;
        logic [4:0]  channel_index;
        logic [6:0]  column_index;
        logic [15:0] line_index;
    } t_result;

    function automatic logic [6:0] column_base(input logic [2:0] marker);
        logic [6:0] base;
        unique case (marker)
            MARKER_IMAGER: base = COLUMN_BASE_IMAGER;
            MARKER_SCAN_A: base = COLUMN_BASE_SCAN_A;
            MARKER_SCAN_B: base = COLUMN_BASE_SCAN_B;
            default:       base = COLUMN_BASE_SCAN_C;
        endcase
        return base;
    endfunction

endpackage

// File: rtl/core/rpcd_in_reg.sv
// Input register stage: captures one payload byte request per cycle while o_in_ready is high.
module rpcd_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_payload_byte,
    input  logic [16:0]          i_payload_length,
    input  logic                 i_start_of_packet,
    input  logic                 i_advance,
    output rpcd_pkg::t_item      o_item
);

    logic        r_valid;
    logic [7:0]  r_byte;
    logic [16:0] r_length;
    logic        r_sop;

    assign o_in_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte   <= i_payload_byte;
            r_length <= i_payload_length;
            r_sop    <= i_start_of_packet;
        end
    end

    assign o_item.valid           = r_valid;
    assign o_item.payload_byte    = r_byte;
    assign o_item.payload_length  = r_length;
    assign o_item.start_of_packet = r_sop;

endmodule

// File: rtl/core/rpcd_tracker.sv
// Packet state tracker: byte position, pair assembly, channel/column/line counters.
module rpcd_tracker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  rpcd_pkg::t_item      i_item,
    output logic                 o_emit,
    output rpcd_pkg::t_result    o_result
);

    logic [10:0]                    r_pos,    n_pos;
    logic [2:0]                     r_marker, n_marker;
    logic                           r_acc,    n_acc;
    logic [7:0]                     r_hold,   n_hold;
    logic [4:0]                     r_chan,   n_chan;
    logic [4:0]                     r_samp,   n_samp;
    logic [rpcd_pkg::LINE_BITS-1:0] r_line,   n_line;

    logic [10:0] w_win;
    logic [2:0]  w_new_marker;
    logic [31:0] w_line_ext;
    logic        w_active;

    assign w_win        = (r_marker == rpcd_pkg::MARKER_IMAGER) ?
                          rpcd_pkg::MARKER1_START : rpcd_pkg::OTHER_START;
    assign w_new_marker = i_item.payload_byte[6:4];
    assign w_line_ext   = 32'(r_line);
    assign w_active     = !i_item.start_of_packet && r_acc && (r_pos < rpcd_pkg::WINDOW_END);

    // Windows start on even bytes, so the odd byte of a position closes a pair.
    assign o_emit = w_active && (r_pos >= w_win) && r_pos[0];

    assign o_result.sample_value  = {r_hold, i_item.payload_byte};
    assign o_result.channel_index = r_chan;
    assign o_result.column_index  = rpcd_pkg::column_base(r_marker) + 7'(r_samp);
    assign o_result.line_index    = w_line_ext[15:0];

    always_comb begin
        n_pos    = r_pos;
        n_marker = r_marker;
        n_acc    = r_acc;
        n_hold   = r_hold;
        n_chan   = r_chan;
        n_samp   = r_samp;
        n_line   = r_line;
        if (i_item.start_of_packet) begin
            n_marker = w_new_marker;
            n_acc    = (i_item.payload_length >= rpcd_pkg::MIN_LENGTH) &&
                       (w_new_marker >= rpcd_pkg::MARKER_IMAGER) &&
                       (w_new_marker <= rpcd_pkg::MARKER_SCAN_C);
            n_pos    = 11'd1;
            n_hold   = 8'd0;
            n_chan   = 5'd0;
            n_samp   = 5'd0;
        end else if (w_active) begin
            n_pos = r_pos + 11'd1;
            if (r_pos >= w_win) begin
                if (!r_pos[0]) begin
                    n_hold = i_item.payload_byte;
                end else if (r_chan == rpcd_pkg::LAST_CHANNEL) begin
                    n_chan = 5'd0;
                    n_samp = r_samp + 5'd1;
                end else begin
                    n_chan = r_chan + 5'd1;
                end
            end
            // Advance the line once the imager window is done.
            if (r_pos == rpcd_pkg::LAST_BYTE && r_marker == rpcd_pkg::MARKER_IMAGER) begin
                n_line = r_line + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_marker <= '0;
            r_acc    <= 1'b0;
            r_hold   <= '0;
            r_chan   <= '0;
            r_samp   <= '0;
            r_line   <= '0;
        end else if (i_step) begin
            r_pos    <= n_pos;
            r_marker <= n_marker;
            r_acc    <= n_acc;
            r_hold   <= n_hold;
            r_chan   <= n_chan;
            r_samp   <= n_samp;
            r_line   <= n_line;
        end
    end

    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chan < rpcd_pkg::NUM_CHANNELS)
        else $error("channel counter out of range");

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= rpcd_pkg::WINDOW_END)
        else $error("byte position ran past window end");

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.start_of_packet) |=> (r_pos == 11'd1 && r_chan == 5'd0))
        else $error("start byte did not restart counters");

    a_emit_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> (r_acc && r_pos[0] && !i_item.start_of_packet))
        else $error("sample emitted outside an accepted packet");

endmodule

// File: rtl/core/radiometer_packet_channel_demux.sv
// A byte waits in the input register; its sample then goes to the result register.
// Throughput: one payload byte per cycle, set by the input register and result register
//   pair; a stalled result register holds every byte behind it, sample or not.
// Reset: i_rst_n synchronous active low; clears both valid flags and all packet counters,
//   including the line counter. Bytes before the first start byte produce nothing.
// Top level of the radiometer packet channel demux.
module radiometer_packet_channel_demux (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_payload_byte,
    input  logic [16:0] i_payload_length,
    input  logic        i_start_of_packet,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_sample_value,
    output logic [4:0]  o_channel_index,
    output logic [6:0]  o_column_index,
    output logic [15:0] o_line_index
);

    rpcd_pkg::t_item   w_item;
    rpcd_pkg::t_result w_result;
    rpcd_pkg::t_result r_result;
    logic              w_emit;
    logic              w_advance;
    logic              r_out_valid;

    // Move a byte out of the input register when the result slot is free or draining.
    assign w_advance = w_item.valid && (!r_out_valid || i_out_ready);

    rpcd_in_reg u_in_reg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_payload_byte   (i_payload_byte),
        .i_payload_length (i_payload_length),
        .i_start_of_packet(i_start_of_packet),
        .i_advance        (w_advance),
        .o_item           (w_item)
    );

    rpcd_tracker u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_item  (w_item),
        .o_emit  (w_emit),
        .o_result(w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sample_value  = r_result.sample_value;
    assign o_channel_index = r_result.channel_index;
    assign o_column_index  = r_result.column_index;
    assign o_line_index    = r_result.line_index;

endmodule
